// ----- sv/hcbt_pkg.sv -----
`timescale 1ns / 1ps
// Package for the Hill cipher block transform: widths, key defaults and
// the modulo-26 helper functions. No dependencies.
package hcbt_pkg;

  localparam int unsigned LetterW = 7;
  localparam int unsigned ValW    = 5;
  localparam int unsigned SumW    = 12;
  localparam int unsigned Key3W   = 45;
  localparam int unsigned Key2W   = 20;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned PosW    = 3;
  localparam int unsigned GroupLen = 5;

  localparam logic [Key3W-1:0]   Key3Reset = 45'd3866681140981;
  localparam logic [Key2W-1:0]   Key2Reset = 20'd379623;
  localparam logic [LetterW-1:0] AsciiBase = 7'd97;
  localparam logic [LetterW-1:0] AsciiTop  = 7'd122;
  localparam logic [PosW-1:0]    LastPos   = 3'd4;
  localparam logic [PosW-1:0]    LastIdx   = 3'd4;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgKey3 = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKey2 = 1'b1;

  // floor(s * 2521 / 2^16) == floor(s / 26) for every s below 2^12
  localparam logic [SumW-1:0] Recip26 = 12'd2521;
  localparam logic [SumW-1:0] Mod26   = 12'd26;

  // (code - 97) mod 26, computed as (code + 7) mod 26
  function automatic logic [ValW-1:0] letter_value(input logic [LetterW-1:0] code);
    logic [LetterW:0] v;
    v = {1'b0, code} + 8'd7;
    for (int i = 0; i < 5; i++) begin
      if (v >= 8'd26) begin
        v = v - 8'd26;
      end
    end
    return v[ValW-1:0];
  endfunction

  function automatic logic [ValW-1:0] mod26(input logic [SumW-1:0] s);
    logic [2*SumW-1:0] p;
    logic [SumW-1:0]   q;
    logic [SumW-1:0]   r;
    p = (2*SumW)'(s) * (2*SumW)'(Recip26);
    q = {4'b0000, p[2*SumW-1:16]};
    r = s - SumW'(q * Mod26);
    return r[ValW-1:0];
  endfunction

endpackage

// ----- sv/hill_cipher_block_transform.sv -----
`timescale 1ns / 1ps
// Hill cipher block transform, modulo 26: groups of five letters, 3x3 and 2x2 key.
// A group moves through the group, sum and letter registers after its fifth letter
// is taken, then leaves one result per cycle, five per group, the last flagged.
// Throughput: one letter per cycle in and one result per cycle out, each unless
// stalled; the five-entry output register sets the output rate. Reset clears
// position, valids and restores the default keys; the letter buffer is not cleared.
module hill_cipher_block_transform (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [hcbt_pkg::LetterW-1:0]   letter_code_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hcbt_pkg::LetterW-1:0]   out_letter_o,
  output logic                           group_last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hcbt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hcbt_pkg::Key3W-1:0]     cfg_data_i
);
  import hcbt_pkg::*;

  logic [Key3W-1:0] key3_q;
  logic [Key2W-1:0] key2_q;
  logic [PosW-1:0]  pos_q;
  logic [ValW-1:0]  pend_q [4];
  logic [ValW-1:0]  grp_q [GroupLen];
  logic             gv_q;
  logic [SumW-1:0]  sum_q [GroupLen];
  logic [SumW-1:0]  sum_d [GroupLen];
  logic             sv_q;
  logic [ValW-1:0]  let_q [GroupLen];
  logic             ov_q;
  logic [PosW-1:0]  idx_q;

  logic [ValW-1:0]  in_val;
  logic             in_acc, out_acc;
  logic             out_free, sum_free, grp_free;
  logic             sum_adv, grp_adv;

  assign cfg_ready_o = 1'b1;
  assign in_val      = letter_value(letter_code_i);

  assign out_acc  = ov_q && !out_stall_i;
  assign out_free = !ov_q || (out_acc && idx_q == LastIdx);
  assign sum_adv  = sv_q && out_free;
  assign sum_free = !sv_q || out_free;
  assign grp_adv  = gv_q && sum_free;
  assign grp_free = !gv_q || sum_free;

  assign in_stall_o = (pos_q == LastPos) && !grp_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o  = ov_q;
  assign out_letter_o = AsciiBase + LetterW'(let_q[idx_q]);
  assign group_last_o = (idx_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key3_q <= Key3Reset;
      key2_q <= Key2Reset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgKey3: key3_q <= cfg_data_i;
        CfgKey2: key2_q <= cfg_data_i[Key2W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SumW'(key3_q[5*(3*r)   +: 5]) * SumW'(grp_q[0])
               + SumW'(key3_q[5*(3*r+1) +: 5]) * SumW'(grp_q[1])
               + SumW'(key3_q[5*(3*r+2) +: 5]) * SumW'(grp_q[2]);
    end
    for (int r = 0; r < 2; r++) begin
      sum_d[3+r] = SumW'(key2_q[5*(2*r)   +: 5]) * SumW'(grp_q[3])
                 + SumW'(key2_q[5*(2*r+1) +: 5]) * SumW'(grp_q[4]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      gv_q  <= 1'b0;
      sv_q  <= 1'b0;
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      if (in_acc) begin
        pos_q <= (pos_q == LastPos) ? '0 : pos_q + 3'd1;
      end
      if (in_acc && pos_q == LastPos) begin
        gv_q <= 1'b1;
      end else if (grp_adv) begin
        gv_q <= 1'b0;
      end
      if (grp_adv) begin
        sv_q <= 1'b1;
      end else if (sum_adv) begin
        sv_q <= 1'b0;
      end
      if (sum_adv) begin
        ov_q  <= 1'b1;
        idx_q <= '0;
      end else if (out_acc) begin
        if (idx_q == LastIdx) begin
          ov_q <= 1'b0;
        end
        idx_q <= (idx_q == LastIdx) ? '0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && pos_q != LastPos) begin
      pend_q[pos_q[1:0]] <= in_val;
    end
    if (in_acc && pos_q == LastPos) begin
      for (int i = 0; i < 4; i++) begin
        grp_q[i] <= pend_q[i];
      end
      grp_q[4] <= in_val;
    end
    if (grp_adv) begin
      for (int i = 0; i < GroupLen; i++) begin
        sum_q[i] <= sum_d[i];
      end
    end
    if (sum_adv) begin
      for (int i = 0; i < GroupLen; i++) begin
        let_q[i] <= mod26(sum_q[i]);
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("group position out of range");

  a_group_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pos_q == LastPos) |=> gv_q)
    else $error("completed group not captured");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_letter_o >= AsciiBase && out_letter_o <= AsciiTop))
    else $error("output letter out of range");

  a_group_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !group_last_o) |=> out_valid_o)
    else $error("group output cut short");
`endif

endmodule
